// ===== hdl/positional_record_list_core_defines.svh =====
// Assertion macros for the positional record list core.
// Included by the top level; depends on nothing else.
`ifndef POSITIONAL_RECORD_LIST_CORE_DEFINES_SVH
`define POSITIONAL_RECORD_LIST_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/prl_pkg.sv =====
// Shared types and codes for the positional record list core.
// Used by prl_cell and positional_record_list_core; no dependencies.
package prl_pkg;

  localparam int unsigned POS_W   = 6;
  localparam int unsigned ISBN_W  = 44;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned HDL_W   = 32;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_LIST   = 3'd4;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_BAD_POS = 2'd2;
  localparam logic [1:0] STS_MISS    = 2'd3;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [POS_W-1:0]  position;
    logic [ISBN_W-1:0] isbn;
    logic [YEAR_W-1:0] year;
    logic [HDL_W-1:0]  record_handle;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  position_out;
    logic [ISBN_W-1:0] isbn_out;
    logic [YEAR_W-1:0] year_out;
    logic [HDL_W-1:0]  handle_out;
    logic [POS_W-1:0]  entry_total;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [ISBN_W-1:0] isbn;
    logic [YEAR_W-1:0] year;
    logic [HDL_W-1:0]  handle;
  } rec_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INS,
    CM_DEL,
    CM_ROT,
    CM_MARK
  } cell_mode_e;

  // Broadcast to every cell; rec carries the new record.
  typedef struct packed {
    cell_mode_e mode;
    rec_t       rec;
  } cell_ctrl_t;

endpackage

// ===== hdl/prl_cell.sv =====
// One slot of the record chain: holds a record and a scan flag.
// Depends on prl_pkg; instantiated by positional_record_list_core.
module prl_cell import prl_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX   = 0,
  localparam int unsigned IW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              match_all_i,
  input  logic [ISBN_W-1:0] key_i,
  input  logic [IW-1:0]     sel_i,
  input  logic [IW-1:0]     tail_i,
  input  logic [CW-1:0]     cnt_i,
  input  rec_t              prev_i,
  input  rec_t              next_i,
  input  rec_t              head_i,
  input  logic              next_flag_i,
  output rec_t              rec_o,
  output logic              flag_o,
  output logic              hit_o,
  output rec_t              rd_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  rec_t rec_q, rec_d;
  logic flag_q, flag_d;

  always_comb begin
    hit_o = (match_all_i || (rec_q.isbn == key_i)) && (MY_CNT < cnt_i);
    rd_o  = (MY_IDX == sel_i) ? rec_q : '0;
  end

  always_comb begin
    rec_d  = rec_q;
    flag_d = flag_q;
    case (ctrl_i.mode)
      CM_INS: begin
        if (MY_IDX == sel_i) begin
          rec_d = ctrl_i.rec;
        end else if (MY_IDX > sel_i) begin
          rec_d = prev_i;
        end
      end
      CM_DEL: begin
        if (MY_IDX >= sel_i) begin
          rec_d = next_i;
        end
      end
      CM_ROT: begin
        // wrap the head around to the tail and drop its flag
        if (MY_IDX == tail_i) begin
          rec_d  = head_i;
          flag_d = 1'b0;
        end else if (MY_IDX < tail_i) begin
          rec_d  = next_i;
          flag_d = next_flag_i;
        end
      end
      CM_MARK: flag_d = hit_o;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o  = rec_q;
  assign flag_o = flag_q;

endmodule

// ===== hdl/positional_record_list_core.sv =====
// Top level of the positional record list: control, count and output register.
// Depends on prl_pkg, prl_cell and positional_record_list_core_defines.svh.
//
// Usage:
//   in channel  (in_valid_i / in_stall_o / in_req_i): one request per item:
//     append, insert, delete, search or list.
//   out channel (out_valid_o / out_stall_i / out_rsp_o): result items; the
//     last item of a request has last set.
//   Append, insert and delete update the list as they are taken; their result sits in the
//   output register the cycle after the request, and a new request is taken
//   whenever that register is empty or being drained.
//   Search and list flag their hits in the cycle the request is taken, then
//   rotate the cell chain one step per cycle, count steps in all (at least
//   one), emitting the head record on each flagged step; the chain ends in
//   its original order. Requests are held off meanwhile.
//   Errors give a single result item with their status; unused opcodes are taken and give no result.
//   A stalled output holds its result; the scan pauses on a flagged step
//   until the output register frees up.
//   Reset empties the list; record storage itself is not cleared.
`include "positional_record_list_core_defines.svh"

module positional_record_list_core import prl_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  cell_ctrl_t    ctrl;
  logic          match_all;
  logic [IW-1:0] sel;
  logic [IW-1:0] tail;
  rec_t          new_rec;
  rec_t          rd_any;
  logic          hit_any;
  logic          in_acc;
  logic          out_free;
  logic          head_flag;
  logic          rest_clear;
  logic          step;
  logic          add_ok;
  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [PW-1:0] ins_w;

  rec_t             cell_rec [DEPTH];
  rec_t             cell_rd  [DEPTH];
  logic [DEPTH-1:0] cell_flag;
  logic [DEPTH-1:0] cell_hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t prev_rec;
    rec_t next_rec;
    logic next_flag;
    if (i == 0) begin : g_first
      assign prev_rec = new_rec;
    end else begin : g_mid
      assign prev_rec = cell_rec[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_rec  = cell_rec[i];
      assign next_flag = 1'b0;
    end else begin : g_inner
      assign next_rec  = cell_rec[i+1];
      assign next_flag = cell_flag[i+1];
    end

    prl_cell #(
      .DEPTH(DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .match_all_i(match_all),
      .key_i      (in_req_i.isbn),
      .sel_i      (sel),
      .tail_i     (tail),
      .cnt_i      (cnt_q),
      .prev_i     (prev_rec),
      .next_i     (next_rec),
      .head_i     (cell_rec[0]),
      .next_flag_i(next_flag),
      .rec_o      (cell_rec[i]),
      .flag_o     (cell_flag[i]),
      .hit_o      (cell_hit[i]),
      .rd_o       (cell_rd[i])
    );
  end

  function automatic out_t make_rsp(input logic [1:0] sts, input logic [POS_W-1:0] pos,
                                    input rec_t rec, input logic [POS_W-1:0] total,
                                    input logic fin);
    out_t r;
    r.status       = sts;
    r.position_out = pos;
    r.isbn_out     = rec.isbn;
    r.year_out     = rec.year;
    r.handle_out   = rec.handle;
    r.entry_total  = total;
    r.last         = fin;
    return r;
  endfunction

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  assign hit_any    = |cell_hit;
  assign head_flag  = cell_flag[0];
  assign rest_clear = (cell_flag >> 1) == '0;

  assign new_rec.isbn   = in_req_i.isbn;
  assign new_rec.year   = in_req_i.year;
  assign new_rec.handle = in_req_i.record_handle;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign step       = (state_q == ST_SCAN) && (!head_flag || out_free);

  assign pos_w = PW'(in_req_i.position);
  assign cnt_w = PW'(cnt_q);
  assign ins_w = ((in_req_i.opcode == OP_INSERT) && (pos_w <= cnt_w)) ? pos_w - PW'(1)
                                                                      : cnt_w;
  assign add_ok = ((in_req_i.opcode == OP_APPEND) || (in_req_i.opcode == OP_INSERT))
                  && !((in_req_i.opcode == OP_INSERT) && (in_req_i.position == '0))
                  && (cnt_q != CW'(DEPTH));

  assign match_all = (in_req_i.opcode == OP_LIST);
  // insert slot for append and insert, addressed slot for delete
  assign sel = ((in_req_i.opcode == OP_APPEND) || (in_req_i.opcode == OP_INSERT))
               ? IW'(ins_w) : IW'(pos_w - PW'(1));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    ctrl.mode      = CM_HOLD;
    ctrl.rec       = new_rec;
    tail           = IW'(cnt_q - CW'(1));

    if (in_acc) begin
      case (in_req_i.opcode)
        OP_APPEND, OP_INSERT: begin
          out_valid_d = 1'b1;
          if ((in_req_i.opcode == OP_INSERT) && (in_req_i.position == '0)) begin
            out_d = make_rsp(STS_BAD_POS, '0, '0, POS_W'(cnt_q), 1'b1);
          end else if (cnt_q == CW'(DEPTH)) begin
            out_d = make_rsp(STS_FULL, '0, '0, POS_W'(cnt_q), 1'b1);
          end else begin
            ctrl.mode = CM_INS;
            cnt_d     = cnt_q + CW'(1);
            out_d     = make_rsp(STS_OK, POS_W'(ins_w + PW'(1)), new_rec,
                                 POS_W'(cnt_q + CW'(1)), 1'b1);
          end
        end
        OP_DELETE: begin
          out_valid_d = 1'b1;
          if (cnt_q == '0) begin
            out_d = make_rsp(STS_MISS, '0, '0, POS_W'(cnt_q), 1'b1);
          end else if ((in_req_i.position == '0) || (pos_w > cnt_w)) begin
            out_d = make_rsp(STS_BAD_POS, '0, '0, POS_W'(cnt_q), 1'b1);
          end else begin
            ctrl.mode = CM_DEL;
            cnt_d     = cnt_q - CW'(1);
            out_d     = make_rsp(STS_OK, in_req_i.position, rd_any,
                                 POS_W'(cnt_q - CW'(1)), 1'b1);
          end
        end
        OP_SEARCH, OP_LIST: begin
          // hit_any covers the empty list for both operations
          if (!hit_any) begin
            out_valid_d = 1'b1;
            out_d       = make_rsp(STS_MISS, '0, '0, POS_W'(cnt_q), 1'b1);
          end else begin
            ctrl.mode = CM_MARK;
            state_d   = ST_SCAN;
            pos_d     = '0;
          end
        end
        default: ;
      endcase
    end else if (step) begin
      ctrl.mode = CM_ROT;
      if (head_flag) begin
        out_valid_d = 1'b1;
        out_d       = make_rsp(STS_OK, POS_W'(pos_q + CW'(1)), cell_rec[0],
                               POS_W'(cnt_q), rest_clear);
      end
      pos_d = pos_q + CW'(1);
      if (pos_q == cnt_q - CW'(1)) begin
        state_d = ST_IDLE;
        pos_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `PRL_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH), "count over depth")
  `PRL_ASSERT_NOW(a_scan_pos, clk_i, rst_ni, state_q == ST_SCAN, pos_q < cnt_q, "scan past count")
  `PRL_ASSERT_NEXT(a_scan_cnt, clk_i, rst_ni, state_q == ST_SCAN, cnt_q == $past(cnt_q), "count moved in scan")
  `PRL_ASSERT_NEXT(a_add_cnt, clk_i, rst_ni, in_acc && add_ok, cnt_q == $past(cnt_q) + CW'(1), "add lost")

endmodule
